[rtl/fbdr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbdr_pkg
// Shared codes and types for the page frame store with drawing and refresh.
// ----------------------------------------------------------------------------
package fbdr_pkg;

   localparam logic [2:0] FUNC_PIXEL   = 3'd0;
   localparam logic [2:0] FUNC_FILL    = 3'd1;
   localparam logic [2:0] FUNC_WINDOW  = 3'd2;
   localparam logic [2:0] FUNC_BITMAP  = 3'd3;
   localparam logic [2:0] FUNC_CLEAR   = 3'd4;
   localparam logic [2:0] FUNC_REFRESH = 3'd5;

   localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
   localparam logic [7:0] CMD_COL_LOW   = 8'h00;
   localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

   localparam int unsigned CMD_BYTES = 3;

   typedef struct packed {
      logic       replace;
      logic       dot;
      logic [7:0] mask;
      logic [7:0] data;
   } rmw_ctrl_type;

endpackage

[rtl/fbdr_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbdr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module fbdr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/fbdr_rmw.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbdr_rmw
// Shared store unit: page/column address and read-modify-write byte merge.
// ----------------------------------------------------------------------------
module fbdr_rmw #(
   parameter int COLUMNS = 128,
   parameter int PAGES   = 8
) (
   input  fbdr_pkg::rmw_ctrl_type                     ctrl,
   input  logic [((PAGES > 1) ? $clog2(PAGES) : 1)-1:0] page,
   input  logic [$clog2(COLUMNS)-1:0]                 col,
   input  logic [7:0]                                 old_byte,
   output logic [$clog2(PAGES * COLUMNS)-1:0]         addr,
   output logic [7:0]                                 new_byte
);

   localparam int AW = $clog2(PAGES * COLUMNS);
   localparam logic [AW-1:0] COLS_A = AW'(COLUMNS);

   assign addr = AW'(page) * COLS_A + AW'(col);

   always_comb begin
      if (ctrl.replace) begin
         new_byte = ctrl.data;
      end else if (ctrl.dot) begin
         new_byte = old_byte | ctrl.mask;
      end else begin
         new_byte = old_byte & ~ctrl.mask;
      end
   end

endmodule

[rtl/page_framebuffer_draw_refresh.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_framebuffer_draw_refresh
// Page organized monochrome frame store with drawing and a refresh stream.
// ----------------------------------------------------------------------------
// usage:
//   req_ carries one drawing or refresh operation per beat; rsp_ returns one
//   beat per request, rsp_out_valid high only for refresh stream bytes.
//   one operation at a time; req_ready drops from accept until the result
//   is loaded into the rsp_ output register.
//   state path from accept to the rsp_ output register, all through one store:
//     window, skipped bitmap byte, command byte, unused code: S_RESP only
//     bitmap byte write: S_WR, S_RESP; refresh data byte: S_RD, S_RESP
//     pixel (read-modify-write): S_RD, S_WR, S_RESP
//     rectangle fill: S_RD, S_WR per touched byte (pages x columns), then S_RESP
//     clear: S_CLR over PAGES*COLUMNS entries, one store entry per cycle, then S_RESP
//   after reset the store is swept to zero over all PAGES*COLUMNS entries with
//   req_ready low.
//   when rsp_ready is low the result holds in rsp_ and the block waits with
//   the next result until the output register frees.
// ----------------------------------------------------------------------------
module page_framebuffer_draw_refresh #(
   parameter int COLUMNS = 128,
   parameter int PAGES   = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_func,
   input  logic [7:0] req_x_start,
   input  logic [7:0] req_y_start,
   input  logic [7:0] req_x_end,
   input  logic [7:0] req_y_end,
   input  logic       req_dot,
   input  logic [2:0] req_page_first,
   input  logic [2:0] req_page_last,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_out_valid,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_is_data,
   output logic       rsp_frame_end
);

   localparam int DEPTH = PAGES * COLUMNS;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(COLUMNS);
   localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int RPW   = $clog2(COLUMNS + fbdr_pkg::CMD_BYTES);
   localparam int ROWS  = 8 * PAGES;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_WR   = 3'd2;
   localparam logic [2:0] S_RESP = 3'd3;
   localparam logic [2:0] S_CLR  = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic          clr_rsp_ff, clr_rsp_in;

   logic [PW-1:0] page_ff, page_in;
   logic [PW-1:0] pend_ff, pend_in;
   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] xs_ff, xs_in;
   logic [CW-1:0] xe_ff, xe_in;
   logic [7:0]    ylo_ff, ylo_in;
   logic [7:0]    yhi_ff, yhi_in;
   logic          dot_ff, dot_in;
   logic          replace_ff, replace_in;
   logic [7:0]    data_ff, data_in;

   logic [RPW-1:0] rpos_ff, rpos_in;
   logic [PW-1:0]  rpage_ff, rpage_in;
   logic [7:0]     win_first_ff, win_first_in;
   logic [7:0]     win_end_ff, win_end_in;
   logic [2:0]     win_last_ff, win_last_in;
   logic [7:0]     cur_col_ff, cur_col_in;
   logic [3:0]     cur_page_ff, cur_page_in;

   logic       res_valid_ff, res_valid_in;
   logic [7:0] res_byte_ff, res_byte_in;
   logic       res_data_ff, res_data_in;
   logic       res_fend_ff, res_fend_in;
   logic       res_ram_ff, res_ram_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_out_valid_ff, rsp_out_valid_in;
   logic [7:0] rsp_out_byte_ff, rsp_out_byte_in;
   logic       rsp_is_data_ff, rsp_is_data_in;
   logic       rsp_frame_end_ff, rsp_frame_end_in;

   fbdr_pkg::rmw_ctrl_type rmw_ctrl;
   logic [AW-1:0] unit_addr;
   logic [7:0]    unit_byte;
   logic [7:0]    ram_rdata;
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [7:0]    ram_wdata;
   logic          ram_re;

   logic [4:0] page5;
   logic [2:0] mask_lo;
   logic [2:0] mask_hi;
   logic [7:0] mask;

   logic       accept;
   logic [8:0] xs9;
   logic [8:0] xe9;
   logic [8:0] xe_clip9;
   logic [8:0] ys9;
   logic [8:0] ye9;
   logic [8:0] ye_clip9;
   logic       fill_ok;
   logic       bm_in_win;
   logic       bm_on_screen;
   logic [7:0] cur_col_next;
   logic [CW-1:0] rcol;

   // mask of rows within the current page
   assign page5   = 5'(page_ff);
   assign mask_lo = (page5 == ylo_ff[7:3]) ? ylo_ff[2:0] : 3'd0;
   assign mask_hi = (page5 == yhi_ff[7:3]) ? yhi_ff[2:0] : 3'd7;
   assign mask    = (8'hFF << mask_lo) & (8'hFF >> (3'd7 - mask_hi));

   assign rmw_ctrl = '{replace: replace_ff, dot: dot_ff, mask: mask, data: data_ff};

   fbdr_rmw #(
      .COLUMNS (COLUMNS),
      .PAGES   (PAGES)
   ) u_rmw (
      .ctrl     (rmw_ctrl),
      .page     (page_ff),
      .col      (col_ff),
      .old_byte (ram_rdata),
      .addr     (unit_addr),
      .new_byte (unit_byte)
   );

   fbdr_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (unit_addr),
      .rd_data (ram_rdata)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   assign xs9      = {1'b0, req_x_start};
   assign xe9      = {1'b0, req_x_end};
   assign xe_clip9 = (xe9 > 9'(COLUMNS - 1)) ? 9'(COLUMNS - 1) : xe9;
   assign ys9      = {1'b0, req_y_start};
   assign ye9      = {1'b0, req_y_end};
   assign ye_clip9 = (ye9 > 9'(ROWS - 1)) ? 9'(ROWS - 1) : ye9;
   assign fill_ok  = (xs9 <= xe_clip9) && (ys9 <= ye_clip9);

   assign bm_in_win    = (cur_page_ff <= {1'b0, win_last_ff}) && (cur_col_ff < win_end_ff);
   assign bm_on_screen = ({1'b0, cur_col_ff} < 9'(COLUMNS))
                         && ({1'b0, cur_page_ff} < 5'(PAGES));
   assign cur_col_next = cur_col_ff + 8'd1;
   assign rcol         = CW'(rpos_ff - RPW'(fbdr_pkg::CMD_BYTES));

   always_comb begin
      state_in         = state_ff;
      clr_in           = clr_ff;
      clr_rsp_in       = clr_rsp_ff;
      page_in          = page_ff;
      pend_in          = pend_ff;
      col_in           = col_ff;
      xs_in            = xs_ff;
      xe_in            = xe_ff;
      ylo_in           = ylo_ff;
      yhi_in           = yhi_ff;
      dot_in           = dot_ff;
      replace_in       = replace_ff;
      data_in          = data_ff;
      rpos_in          = rpos_ff;
      rpage_in         = rpage_ff;
      win_first_in     = win_first_ff;
      win_end_in       = win_end_ff;
      win_last_in      = win_last_ff;
      cur_col_in       = cur_col_ff;
      cur_page_in      = cur_page_ff;
      res_valid_in     = res_valid_ff;
      res_byte_in      = res_byte_ff;
      res_data_in      = res_data_ff;
      res_fend_in      = res_fend_ff;
      res_ram_in       = res_ram_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_out_valid_in = rsp_out_valid_ff;
      rsp_out_byte_in  = rsp_out_byte_ff;
      rsp_is_data_in   = rsp_is_data_ff;
      rsp_frame_end_in = rsp_frame_end_ff;
      ram_we           = 1'b0;
      ram_waddr        = unit_addr;
      ram_wdata        = unit_byte;
      ram_re           = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_valid_in = 1'b0;
               res_byte_in  = 8'h00;
               res_data_in  = 1'b0;
               res_fend_in  = 1'b0;
               res_ram_in   = 1'b0;
               dot_in       = req_dot;
               replace_in   = 1'b0;
               data_in      = req_data_byte;
               state_in     = S_RESP;
               case (req_func)
                  fbdr_pkg::FUNC_PIXEL: begin
                     if (xs9 < 9'(COLUMNS) && ys9 < 9'(ROWS)) begin
                        xs_in    = CW'(req_x_start);
                        xe_in    = CW'(req_x_start);
                        col_in   = CW'(req_x_start);
                        ylo_in   = req_y_start;
                        yhi_in   = req_y_start;
                        page_in  = PW'(req_y_start[7:3]);
                        pend_in  = PW'(req_y_start[7:3]);
                        state_in = S_RD;
                     end
                  end
                  fbdr_pkg::FUNC_FILL: begin
                     if (fill_ok) begin
                        xs_in    = CW'(req_x_start);
                        xe_in    = CW'(xe_clip9);
                        col_in   = CW'(req_x_start);
                        ylo_in   = req_y_start;
                        yhi_in   = ye_clip9[7:0];
                        page_in  = PW'(req_y_start[7:3]);
                        pend_in  = PW'(ye_clip9[7:3]);
                        state_in = S_RD;
                     end
                  end
                  fbdr_pkg::FUNC_WINDOW: begin
                     win_first_in = req_x_start;
                     win_end_in   = req_x_end;
                     win_last_in  = req_page_last;
                     cur_col_in   = req_x_start;
                     cur_page_in  = {1'b0, req_page_first};
                  end
                  fbdr_pkg::FUNC_BITMAP: begin
                     if (bm_in_win) begin
                        if (bm_on_screen) begin
                           xs_in      = CW'(cur_col_ff);
                           xe_in      = CW'(cur_col_ff);
                           col_in     = CW'(cur_col_ff);
                           page_in    = PW'(cur_page_ff);
                           pend_in    = PW'(cur_page_ff);
                           replace_in = 1'b1;
                           state_in   = S_WR;
                        end
                        if (cur_col_next >= win_end_ff) begin
                           cur_col_in  = win_first_ff;
                           cur_page_in = cur_page_ff + 4'd1;
                        end else begin
                           cur_col_in = cur_col_next;
                        end
                     end
                  end
                  fbdr_pkg::FUNC_CLEAR: begin
                     clr_in     = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = S_CLR;
                  end
                  fbdr_pkg::FUNC_REFRESH: begin
                     res_valid_in = 1'b1;
                     if (rpos_ff == RPW'(0)) begin
                        res_byte_in = fbdr_pkg::CMD_PAGE_BASE + 8'(rpage_ff);
                     end else if (rpos_ff == RPW'(1)) begin
                        res_byte_in = fbdr_pkg::CMD_COL_LOW;
                     end else if (rpos_ff == RPW'(2)) begin
                        res_byte_in = fbdr_pkg::CMD_COL_HIGH;
                     end else begin
                        res_data_in = 1'b1;
                        res_ram_in  = 1'b1;
                        res_fend_in = (rcol == CW'(COLUMNS - 1))
                                      && (rpage_ff == PW'(PAGES - 1));
                        page_in     = rpage_ff;
                        col_in      = rcol;
                        state_in    = S_RD;
                     end
                     if (rpos_ff == RPW'(COLUMNS + fbdr_pkg::CMD_BYTES - 1)) begin
                        rpos_in  = '0;
                        rpage_in = (rpage_ff == PW'(PAGES - 1)) ? '0 : rpage_ff + PW'(1);
                     end else begin
                        rpos_in = rpos_ff + RPW'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_RD: begin
            ram_re   = 1'b1;
            state_in = res_ram_ff ? S_RESP : S_WR;
         end
         S_WR: begin
            ram_we = 1'b1;
            if (col_ff == xe_ff) begin
               col_in = xs_ff;
               if (page_ff == pend_ff) begin
                  state_in = S_RESP;
               end else begin
                  page_in  = page_ff + PW'(1);
                  state_in = S_RD;
               end
            end else begin
               col_in   = col_ff + CW'(1);
               state_in = S_RD;
            end
         end
         S_CLR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = 8'h00;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = clr_rsp_ff ? S_RESP : S_IDLE;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in     = 1'b1;
               rsp_out_valid_in = res_valid_ff;
               rsp_out_byte_in  = res_ram_ff ? ram_rdata : res_byte_ff;
               rsp_is_data_in   = res_data_ff;
               rsp_frame_end_in = res_fend_ff;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         rpos_ff      <= '0;
         rpage_ff     <= '0;
         win_first_ff <= '0;
         win_end_ff   <= '0;
         win_last_ff  <= '0;
         cur_col_ff   <= '0;
         cur_page_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_rsp_ff   <= clr_rsp_in;
         rpos_ff      <= rpos_in;
         rpage_ff     <= rpage_in;
         win_first_ff <= win_first_in;
         win_end_ff   <= win_end_in;
         win_last_ff  <= win_last_in;
         cur_col_ff   <= cur_col_in;
         cur_page_ff  <= cur_page_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff          <= page_in;
      pend_ff          <= pend_in;
      col_ff           <= col_in;
      xs_ff            <= xs_in;
      xe_ff            <= xe_in;
      ylo_ff           <= ylo_in;
      yhi_ff           <= yhi_in;
      dot_ff           <= dot_in;
      replace_ff       <= replace_in;
      data_ff          <= data_in;
      res_valid_ff     <= res_valid_in;
      res_byte_ff      <= res_byte_in;
      res_data_ff      <= res_data_in;
      res_fend_ff      <= res_fend_in;
      res_ram_ff       <= res_ram_in;
      rsp_out_valid_ff <= rsp_out_valid_in;
      rsp_out_byte_ff  <= rsp_out_byte_in;
      rsp_is_data_ff   <= rsp_is_data_in;
      rsp_frame_end_ff <= rsp_frame_end_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_valid = rsp_out_valid_ff;
   assign rsp_out_byte  = rsp_out_byte_ff;
   assign rsp_is_data   = rsp_is_data_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

endmodule

[rtl/fbdr_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbdr_chk
// Port level checks for the page frame store, bound to the top level.
// ----------------------------------------------------------------------------
module fbdr_chk (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_out_valid,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_is_data,
   input logic       rsp_frame_end
);

   // store sweep keeps the request side closed right after reset
   a_sweep_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !req_ready)
      else $error("request accepted during post reset store sweep");

   // one operation in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready held high after a request beat");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_out_byte)))
      else $error("stalled response beat dropped or changed");

   a_data_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_is_data || rsp_frame_end)) |-> rsp_out_valid)
      else $error("data or frame end flag on a beat without refresh byte");

   a_frame_end_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_end) |-> rsp_is_data)
      else $error("frame end on a command byte");

endmodule

bind page_framebuffer_draw_refresh fbdr_chk u_fbdr_chk (.*);
